@@ design/itrq_pkg.sv @@
// Shared types, codes and constants of the quarter-turn tile rotator.
package itrq_pkg;

   // Default configuration of the store
   localparam int MAX_SIDE_DEF   = 64;
   localparam int PIXEL_BITS_DEF = 24;

   // Fixed field widths
   localparam int PIX_FIELD_W = 24;
   localparam int ANGLE_W     = 10;
   localparam int SIZE_W      = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHOLE = 3'd3;

   // Supported angle magnitudes
   localparam logic [ANGLE_W-1:0] ANGLE_0   = 10'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_90  = 10'd90;
   localparam logic [ANGLE_W-1:0] ANGLE_180 = 10'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_270 = 10'd270;
   localparam logic [ANGLE_W-1:0] ANGLE_360 = 10'd360;

   // Quarter turns
   localparam logic [1:0] TURN_0 = 2'd0;
   localparam logic [1:0] TURN_1 = 2'd1;
   localparam logic [1:0] TURN_2 = 2'd2;
   localparam logic [1:0] TURN_3 = 2'd3;

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNSUPPORTED = 2'd1,
      STATUS_NOT_SQUARE  = 2'd2
   } status_type;

   typedef struct packed {
      logic                   operation;
      logic [PIX_FIELD_W-1:0] pixel_in;
   } req_word_type;

   typedef struct packed {
      logic [PIX_FIELD_W-1:0] pixel_out;
      logic                   last;
      status_type             status;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_en;
      logic read_start;
      logic mem_rd;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_read;
      logic read_err;
   } dp_stat_type;

endpackage

@@ design/image_tile_rotate_quarter_unit.sv @@
// A load is written to the tile store as it is taken; a read's result passes through the address register,
// then the store's registered read port; an error result skips the store read.
// One load per cycle while no read is in progress; a read occupies the block, and the next word is
// taken only after its result is delivered, also while the result is stalled.
// Reset (synchronous, active high) clears counters, controller and config registers;
// the tile store is not cleared and holds its old contents.
module image_tile_rotate_quarter_unit #(
   parameter int MAX_SIDE   = itrq_pkg::MAX_SIDE_DEF,
   parameter int PIXEL_BITS = itrq_pkg::PIXEL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  itrq_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output itrq_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_write,
   input  logic [itrq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [itrq_pkg::CSR_DATA_W-1:0]  csr_data
);

   itrq_pkg::ctrl_cmd_type cmd;
   itrq_pkg::dp_stat_type  stat;

   // controller
   itrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   itrq_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_word  (rsp_word)
   );

endmodule

@@ design/itrq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module itrq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/itrq_ctrl.sv @@
// Controller state machine of the tile rotator: sequences loads, reads and results.
module itrq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  itrq_pkg::dp_stat_type stat,
   output itrq_pkg::ctrl_cmd_type cmd
);

   itrq_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      cmd.load_en    = 1'b0;
      cmd.read_start = 1'b0;
      cmd.mem_rd     = 1'b0;
      case (state_ff)
         itrq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (stat.is_read) begin
                  cmd.read_start = 1'b1;
                  state_in = stat.read_err ? itrq_pkg::ST_RESP : itrq_pkg::ST_READ;
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         itrq_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = itrq_pkg::ST_RESP;
         end
         itrq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = itrq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itrq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/itrq_datapath.sv @@
// Datapath of the tile rotator: config registers, counters, address math and tile store.
module itrq_datapath #(
   parameter int MAX_SIDE   = itrq_pkg::MAX_SIDE_DEF,
   parameter int PIXEL_BITS = itrq_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  itrq_pkg::ctrl_cmd_type              cmd,
   output itrq_pkg::dp_stat_type               stat,
   input  itrq_pkg::req_word_type              req_word,
   input  logic                                csr_write,
   input  logic [itrq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [itrq_pkg::CSR_DATA_W-1:0]     csr_data,
   output itrq_pkg::rsp_word_type              rsp_word
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int POS_W  = $clog2(MAX_SIDE);
   localparam int PROD_W = 2 * SIDE_W;

   // configuration registers
   logic [itrq_pkg::ANGLE_W-1:0] angle_ff;
   logic [itrq_pkg::SIZE_W-1:0]  rows_ff, cols_ff;
   logic                         whole_ff;

   // counters
   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic [POS_W-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;

   // read address and result tags
   logic [ADDR_W-1:0]    addr_ff;
   logic                 last_ff;
   itrq_pkg::status_type status_ff;

   logic [SIDE_W-1:0]            rows_c, cols_c, orows, ocols;
   logic [SIDE_W-1:0]            row_e, col_e, sr, sc;
   logic [PROD_W-1:0]            total, prod;
   logic [itrq_pkg::ANGLE_W-1:0] mag;
   logic [1:0]                   turns;
   logic                         angle_bad, not_square, fin, csr_hit;
   itrq_pkg::status_type         status_now;
   logic [PIXEL_BITS-1:0]        rd_pix;

   // clamp region sizes into 1..MAX_SIDE
   always_comb begin
      if (rows_ff == '0) begin
         rows_c = SIDE_W'(1);
      end else if (int'(rows_ff) > MAX_SIDE) begin
         rows_c = SIDE_W'(MAX_SIDE);
      end else begin
         rows_c = SIDE_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_c = SIDE_W'(1);
      end else if (int'(cols_ff) > MAX_SIDE) begin
         cols_c = SIDE_W'(MAX_SIDE);
      end else begin
         cols_c = SIDE_W'(cols_ff);
      end
      total = PROD_W'(rows_c) * PROD_W'(cols_c);
   end

   // angle decode: magnitude, quarter turns and error status
   always_comb begin
      mag       = angle_ff[itrq_pkg::ANGLE_W-1] ? (~angle_ff + 1'b1) : angle_ff;
      angle_bad = 1'b0;
      if (mag == itrq_pkg::ANGLE_90) begin
         turns = angle_ff[itrq_pkg::ANGLE_W-1] ? itrq_pkg::TURN_3 : itrq_pkg::TURN_1;
      end else if (mag == itrq_pkg::ANGLE_180) begin
         turns = itrq_pkg::TURN_2;
      end else if (mag == itrq_pkg::ANGLE_270) begin
         turns = angle_ff[itrq_pkg::ANGLE_W-1] ? itrq_pkg::TURN_1 : itrq_pkg::TURN_3;
      end else begin
         turns     = itrq_pkg::TURN_0;
         angle_bad = (mag != itrq_pkg::ANGLE_0) && (mag != itrq_pkg::ANGLE_360);
      end
      not_square = (turns != itrq_pkg::TURN_0) && (rows_c != cols_c) && !whole_ff;
      if (angle_bad) begin
         status_now = itrq_pkg::STATUS_UNSUPPORTED;
      end else if (not_square) begin
         status_now = itrq_pkg::STATUS_NOT_SQUARE;
      end else begin
         status_now = itrq_pkg::STATUS_OK;
      end
   end

   assign stat.is_read  = (req_word.operation == itrq_pkg::OP_READ);
   assign stat.read_err = (status_now != itrq_pkg::STATUS_OK);

   // output position, source position and store address
   always_comb begin
      orows = turns[0] ? cols_c : rows_c;
      ocols = turns[0] ? rows_c : cols_c;
      if ((SIDE_W'(out_row_ff) >= orows) || (SIDE_W'(out_col_ff) >= ocols)) begin
         row_e = '0;
         col_e = '0;
      end else begin
         row_e = SIDE_W'(out_row_ff);
         col_e = SIDE_W'(out_col_ff);
      end
      case (turns)
         itrq_pkg::TURN_1: begin
            sr = rows_c - 1'b1 - col_e;
            sc = row_e;
         end
         itrq_pkg::TURN_2: begin
            sr = rows_c - 1'b1 - row_e;
            sc = cols_c - 1'b1 - col_e;
         end
         itrq_pkg::TURN_3: begin
            sr = col_e;
            sc = cols_c - 1'b1 - row_e;
         end
         default: begin
            sr = row_e;
            sc = col_e;
         end
      endcase
      prod = PROD_W'(sr) * PROD_W'(cols_c) + PROD_W'(sc);
      fin  = (row_e == orows - 1'b1) && (col_e == ocols - 1'b1);
   end

   // counter updates
   always_comb begin
      load_count_in = load_count_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      case (csr_index)
         itrq_pkg::CSR_ANGLE, itrq_pkg::CSR_ROWS,
         itrq_pkg::CSR_COLS, itrq_pkg::CSR_WHOLE: csr_hit = csr_write;
         default:                                 csr_hit = 1'b0;
      endcase
      if (csr_hit) begin
         load_count_in = '0;
         out_row_in    = '0;
         out_col_in    = '0;
      end else if (cmd.load_en) begin
         if (PROD_W'(load_count_ff) < total) begin
            load_count_in = load_count_ff + 1'b1;
         end
      end else if (cmd.read_start && !stat.read_err) begin
         if (fin) begin
            load_count_in = '0;
            out_row_in    = '0;
            out_col_in    = '0;
         end else if (col_e == ocols - 1'b1) begin
            out_col_in = '0;
            out_row_in = POS_W'(row_e + 1'b1);
         end else begin
            out_row_in = POS_W'(row_e);
            out_col_in = POS_W'(col_e + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
      end else begin
         load_count_ff <= load_count_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         rows_ff  <= itrq_pkg::SIZE_W'(1);
         cols_ff  <= itrq_pkg::SIZE_W'(1);
         whole_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            itrq_pkg::CSR_ANGLE: angle_ff <= csr_data[itrq_pkg::ANGLE_W-1:0];
            itrq_pkg::CSR_ROWS:  rows_ff  <= csr_data[itrq_pkg::SIZE_W-1:0];
            itrq_pkg::CSR_COLS:  cols_ff  <= csr_data[itrq_pkg::SIZE_W-1:0];
            itrq_pkg::CSR_WHOLE: whole_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // read address and result tags, latched when a read is taken
   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         addr_ff   <= prod[ADDR_W-1:0];
         status_ff <= status_now;
         last_ff   <= stat.read_err | fin;
      end
   end

   // tile store
   itrq_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_en && (PROD_W'(load_count_ff) < total)),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (PIXEL_BITS'(req_word.pixel_in)),
      .rd_en   (cmd.mem_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_pix)
   );

   // result word
   always_comb begin
      rsp_word.status    = status_ff;
      rsp_word.last      = last_ff;
      rsp_word.pixel_out = (status_ff == itrq_pkg::STATUS_OK) ?
                           itrq_pkg::PIX_FIELD_W'(rd_pix) : '0;
   end

endmodule

@@ design/itrq_checker.sv @@
// Port-level checker of the tile rotator and its bind to the top level.
module itrq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input itrq_pkg::req_word_type           req_word,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input itrq_pkg::rsp_word_type           rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // no new word is taken while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   // a taken read occupies the block until its result leaves
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.operation == itrq_pkg::OP_READ) |=> req_stall)
      else $error("read did not occupy the block");

   // error results are flagged last and carry a zero pixel
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != itrq_pkg::STATUS_OK) |->
         rsp_word.last && (rsp_word.pixel_out == '0))
      else $error("malformed error result");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind image_tile_rotate_quarter_unit itrq_checker u_checker (.*);
